@@ design/smap_pkg.sv @@
// shared types and constants for the sphere-map texel address unit
`timescale 1ns / 1ps
`default_nettype none

package smap_pkg;

    localparam int MAX_TEX_DIM   = 4096;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 12;
    localparam int INDEX_W       = 24;
    localparam int DIR_W         = 16;
    localparam int GUARD_BITS    = 8;

    // square root chain: one result bit per cell
    localparam int SQ_RAD_W      = 52;
    localparam int SQ_ROOT_W     = SQ_RAD_W / 2;
    localparam int SQ_REM_W      = SQ_ROOT_W + 2;
    localparam int SQ_CELLS      = SQ_ROOT_W;

    // divider chain: one quotient bit per cell
    localparam int DIV_Q_W       = 13;
    localparam int DIV_DEN_W     = 26;
    localparam int DIV_NUM_W     = DIV_DEN_W - 1 + DIV_Q_W;
    localparam int DIV_CELLS     = DIV_Q_W;

    typedef enum logic [1:0] {
        CFG_TEX_WIDTH   = 2'd0,
        CFG_TEX_HEIGHT  = 2'd1,
        CFG_TEX_PRESENT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DIV_Q_W-1:0]   lo;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_Q_W-1:0]   q;
        logic [DIV_DEN_W-1:0] den;
    } div_t;

endpackage

`default_nettype wire

@@ design/smap_sqrt_cell.sv @@
// one digit step of the pipelined integer square root
`timescale 1ns / 1ps
`default_nettype none

module smap_sqrt_cell
    import smap_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire sq_t  d_in,
    output sq_t       d_out
);

    sq_t                  d_reg;
    sq_t                  d_next;
    logic [SQ_REM_W+1:0]  rem_sh;
    logic [SQ_REM_W+1:0]  trial;

    always_comb
    begin
        rem_sh = {d_in.rem, d_in.rad[SQ_RAD_W-1 -: 2]};
        trial  = {2'b00, d_in.root, 2'b01};
        d_next.rad = {d_in.rad[SQ_RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            d_next.rem  = SQ_REM_W'(rem_sh - trial);
            d_next.root = {d_in.root[SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem  = rem_sh[SQ_REM_W-1:0];
            d_next.root = {d_in.root[SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

@@ design/smap_div_cell.sv @@
// one restoring step of the pipelined divider
`timescale 1ns / 1ps
`default_nettype none

module smap_div_cell
    import smap_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire div_t d_in,
    output div_t      d_out
);

    div_t                 d_reg;
    div_t                 d_next;
    logic [DIV_DEN_W:0]   rem_sh;

    always_comb
    begin
        rem_sh     = {d_in.rem, d_in.lo[DIV_Q_W-1]};
        d_next.lo  = {d_in.lo[DIV_Q_W-2:0], 1'b0};
        d_next.den = d_in.den;
        if (rem_sh >= {1'b0, d_in.den})
        begin
            d_next.rem = DIV_DEN_W'(rem_sh - {1'b0, d_in.den});
            d_next.q   = {d_in.q[DIV_Q_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = rem_sh[DIV_DEN_W-1:0];
            d_next.q   = {d_in.q[DIV_Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

@@ design/sphere_map_texel_address.sv @@
// sphere-map texel address unit: top level with pipeline control
// pipeline: 72 stages behind the input stage, then the output register, which holds the
// result until the receiver takes it
// throughput: one item per cycle unless stalled, every square root and divider cell takes
// a new item each cycle unless stalled; the pipeline only stalls when its last stage and
// the output register both hold results and the receiver is not ready
// reset: rst_n clears stage valid bits and loads width 1, height 1, no texture present
`timescale 1ns / 1ps
`default_nettype none

module sphere_map_texel_address
    import smap_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [DIM_W-1:0]         cfg_data,
    input  wire logic                     dir_valid,
    output logic                          dir_ready,
    input  wire logic signed [DIR_W-1:0]  dir_x,
    input  wire logic signed [DIR_W-1:0]  dir_y,
    input  wire logic signed [DIR_W-1:0]  dir_z,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic                          valid_res,
    output logic [COORD_W-1:0]            texel_x,
    output logic [COORD_W-1:0]            texel_y,
    output logic [INDEX_W-1:0]            texel_index
);

    localparam int LAT = 2 + SQ_CELLS + 2 + SQ_CELLS + 2 + DIV_CELLS + 2;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
    } side1_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic                    zflag;
    } side2_t;

    typedef struct packed {
        logic zflag;
        logic ovfx;
        logic ovfy;
    } side3_t;

    // configuration
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               present_reg;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [COORD_W-1:0] w_m1;
    logic [COORD_W-1:0] h_m1;

    logic               en;
    logic [LAT-1:0]     vld_reg;

    // stage 1 and 2
    side1_t             s1_reg;
    logic [31:0]        xx_reg, yy_reg, zz_reg;
    side1_t             s2_reg;
    logic [31:0]        sum_reg;

    sq_t                sq1 [0:SQ_CELLS];
    side1_t             side1_reg [0:SQ_CELLS-1];

    // stage 3 and 4
    logic [23:0]             len_reg;
    logic [24:0]             wz_reg;
    side2_t                  s3_reg;
    logic signed [25:0]      wzs;
    logic [48:0]             prod_reg;
    side2_t                  s4_reg;

    sq_t                sq2 [0:SQ_CELLS];
    side2_t             side2_reg [0:SQ_CELLS-1];

    // stage 5 and 6
    logic [24:0]             m_val;
    logic signed [26:0]      numx_s, numy_s;
    logic [25:0]             numx_reg, numy_reg;
    logic [24:0]             m_reg;
    logic                    zf5_reg;
    logic [DIV_NUM_W-1:0]    nx_reg, ny_reg;
    logic [DIV_DEN_W-1:0]    den_reg;
    logic                    zf6_reg;
    side3_t                  side3_in;

    div_t               dvx [0:DIV_CELLS];
    div_t               dvy [0:DIV_CELLS];
    side3_t             side3_reg [0:DIV_CELLS-1];

    // stage 7 and 8
    logic [COORD_W-1:0]  tx7_reg, ty7_reg;
    logic [COORD_W-1:0]  tx_next, ty_next;
    logic [COORD_W-1:0]  tx8_reg, ty8_reg;
    logic [INDEX_W-1:0]  idx8_reg;
    logic                pres8_reg;
    logic [DIM_W+COORD_W-1:0] idx_sum;

    // output register
    logic                out_v_reg;
    logic                out_p_reg;
    logic [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [INDEX_W-1:0]  out_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_W'(1);
            height_reg  <= DIM_W'(1);
            present_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TEX_WIDTH:   width_reg   <= cfg_data;
                CFG_TEX_HEIGHT:  height_reg  <= cfg_data;
                CFG_TEX_PRESENT: present_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign w_eff = (width_reg == '0) ? DIM_W'(1) :
                   (width_reg > DIM_W'(MAX_TEX_DIM)) ? DIM_W'(MAX_TEX_DIM) : width_reg;
    assign h_eff = (height_reg == '0) ? DIM_W'(1) :
                   (height_reg > DIM_W'(MAX_TEX_DIM)) ? DIM_W'(MAX_TEX_DIM) : height_reg;
    assign w_m1 = COORD_W'(w_eff - DIM_W'(1));
    assign h_m1 = COORD_W'(h_eff - DIM_W'(1));

    // freeze only when the last stage cannot move into the output register
    assign en        = !(vld_reg[LAT-1] && out_v_reg && !res_ready);
    assign dir_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], dir_valid};
        end
    end

    // squares, then their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= '{x: dir_x, y: dir_y, z: dir_z};
            xx_reg  <= 32'(dir_x * dir_x);
            yy_reg  <= 32'(dir_y * dir_y);
            zz_reg  <= 32'(dir_z * dir_z);
            s2_reg  <= s1_reg;
            sum_reg <= xx_reg + yy_reg + zz_reg;
        end
    end

    // |v| with guard bits
    assign sq1[0] = '{rad: {4'b0000, sum_reg, 16'h0000}, rem: '0, root: '0};

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sq1
        smap_sqrt_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (sq1[i]),
            .d_out (sq1[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= s2_reg;
            for (int i = 1; i < SQ_CELLS; i++)
            begin
                side1_reg[i] <= side1_reg[i-1];
            end
        end
    end

    // z + |v|, clipped at zero
    assign wzs = $signed({2'b00, sq1[SQ_CELLS].root[23:0]})
               + $signed({{2{side1_reg[SQ_CELLS-1].z[DIR_W-1]}},
                          side1_reg[SQ_CELLS-1].z, 8'h00});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= sq1[SQ_CELLS].root[23:0];
            wz_reg  <= wzs[25] ? 25'd0 : wzs[24:0];
            s3_reg  <= '{x: side1_reg[SQ_CELLS-1].x, y: side1_reg[SQ_CELLS-1].y,
                         zflag: (wzs[25] || wzs == '0)};
            prod_reg <= 49'(len_reg * wz_reg);
            s4_reg   <= s3_reg;
        end
    end

    assign sq2[0] = '{rad: {2'b00, prod_reg, 1'b0}, rem: '0, root: '0};

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sq2
        smap_sqrt_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (sq2[i]),
            .d_out (sq2[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg[0] <= s4_reg;
            for (int i = 1; i < SQ_CELLS; i++)
            begin
                side2_reg[i] <= side2_reg[i-1];
            end
        end
    end

    // numerators m + x and m + y, negative ones read as zero
    assign m_val  = (sq2[SQ_CELLS].root[24:0] == '0) ? 25'd1 : sq2[SQ_CELLS].root[24:0];
    assign numx_s = $signed({2'b00, m_val})
                  + $signed({{3{side2_reg[SQ_CELLS-1].x[DIR_W-1]}},
                             side2_reg[SQ_CELLS-1].x, 8'h00});
    assign numy_s = $signed({2'b00, m_val})
                  + $signed({{3{side2_reg[SQ_CELLS-1].y[DIR_W-1]}},
                             side2_reg[SQ_CELLS-1].y, 8'h00});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg <= numx_s[26] ? 26'd0 : numx_s[25:0];
            numy_reg <= numy_s[26] ? 26'd0 : numy_s[25:0];
            m_reg    <= m_val;
            zf5_reg  <= side2_reg[SQ_CELLS-1].zflag;
            nx_reg   <= DIV_NUM_W'(numx_reg * w_m1);
            ny_reg   <= DIV_NUM_W'(numy_reg * h_m1);
            den_reg  <= {m_reg, 1'b0};
            zf6_reg  <= zf5_reg;
        end
    end

    // quotient wider than the divider chain saturates
    assign side3_in = '{zflag: zf6_reg,
                        ovfx: ({1'b0, nx_reg[DIV_NUM_W-1:DIV_Q_W]} >= den_reg),
                        ovfy: ({1'b0, ny_reg[DIV_NUM_W-1:DIV_Q_W]} >= den_reg)};
    assign dvx[0] = '{lo: nx_reg[DIV_Q_W-1:0], rem: {1'b0, nx_reg[DIV_NUM_W-1:DIV_Q_W]},
                      q: '0, den: den_reg};
    assign dvy[0] = '{lo: ny_reg[DIV_Q_W-1:0], rem: {1'b0, ny_reg[DIV_NUM_W-1:DIV_Q_W]},
                      q: '0, den: den_reg};

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        smap_div_cell u_cell_x (
            .clk   (clk),
            .en    (en),
            .d_in  (dvx[i]),
            .d_out (dvx[i+1])
        );
        smap_div_cell u_cell_y (
            .clk   (clk),
            .en    (en),
            .d_in  (dvy[i]),
            .d_out (dvy[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg[0] <= side3_in;
            for (int i = 1; i < DIV_CELLS; i++)
            begin
                side3_reg[i] <= side3_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (side3_reg[DIV_CELLS-1].zflag)
        begin
            tx_next = '0;
            ty_next = h_eff[DIM_W-1:1];
        end
        else
        begin
            tx_next = (side3_reg[DIV_CELLS-1].ovfx || dvx[DIV_CELLS].q > {1'b0, w_m1}) ?
                      w_m1 : dvx[DIV_CELLS].q[COORD_W-1:0];
            ty_next = (side3_reg[DIV_CELLS-1].ovfy || dvy[DIV_CELLS].q > {1'b0, h_m1}) ?
                      h_m1 : dvy[DIV_CELLS].q[COORD_W-1:0];
        end
    end

    assign idx_sum = {{DIM_W{1'b0}}, tx7_reg} + (DIM_W+COORD_W)'(ty7_reg * w_eff);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx7_reg   <= tx_next;
            ty7_reg   <= ty_next;
            tx8_reg   <= present_reg ? tx7_reg : '0;
            ty8_reg   <= present_reg ? ty7_reg : '0;
            idx8_reg  <= present_reg ? idx_sum[INDEX_W-1:0] : '0;
            pres8_reg <= present_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (!out_v_reg || res_ready)
        begin
            out_v_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || res_ready)
        begin
            out_p_reg <= pres8_reg;
            out_x_reg <= tx8_reg;
            out_y_reg <= ty8_reg;
            out_i_reg <= idx8_reg;
        end
    end

    assign res_valid   = out_v_reg;
    assign valid_res   = out_p_reg;
    assign texel_x     = out_x_reg;
    assign texel_y     = out_y_reg;
    assign texel_index = out_i_reg;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !dir_ready |-> (res_valid && !res_ready && vld_reg[LAT-1]))
        else $error("input stalled without a blocked result");

    a_no_tex_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !valid_res) |-> (texel_x == '0 && texel_y == '0 && texel_index == '0))
        else $error("result without texture is not zero");

    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAT-1] && pres8_reg) |-> (tx8_reg <= w_m1 && ty8_reg <= h_m1))
        else $error("texel coordinate beyond image");
`endif

endmodule

`default_nettype wire

@@ tb/sv/sphere_map_texel_address_test.sv @@
// self-checking testbench for the sphere-map texel address unit
`timescale 1ns / 1ps

module sphere_map_texel_address_test;
    import smap_pkg::*;

    typedef struct {
        bit                   ok;
        bit [COORD_W-1:0]     tx;
        bit [COORD_W-1:0]     ty;
        bit [INDEX_W-1:0]     idx;
    } texel_t;

    class texel_scoreboard;
        texel_t          pending_texels[$];
        bit [DIM_W-1:0]  width_reg = 1;
        bit [DIM_W-1:0]  height_reg = 1;
        bit              present_reg = 0;
        int              errors = 0;
        int              seen = 0;
        int              wz_zero = 0;

        function automatic longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function automatic longint unsigned clamp_dim(bit [DIM_W-1:0] r);
            if (r == 0)
                return 1;
            if (r > MAX_TEX_DIM)
                return MAX_TEX_DIM;
            return r;
        endfunction

        // floor((m + 256c) * (d-1) / 2m), clamped to the image
        function automatic longint unsigned axis_texel(longint c, longint unsigned m,
                                                       longint unsigned d);
            longint          num;
            longint unsigned t;
            num = longint'(m) + c * 256;
            if (num <= 0)
                return 0;
            t = (longint'(num) * (d - 1)) / (2 * m);
            if (t > d - 1)
                t = d - 1;
            return t;
        endfunction

        function void note_dir(bit signed [DIR_W-1:0] x, bit signed [DIR_W-1:0] y,
                               bit signed [DIR_W-1:0] z);
            texel_t          e;
            longint          xs, ys, zs, wzs;
            longint unsigned w, h, s, len, wz, m, tx, ty;
            xs = x;
            ys = y;
            zs = z;
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            e = '{0, 0, 0, 0};
            if (present_reg)
            begin
                s = xs * xs + ys * ys + zs * zs;
                len = int_sqrt(s << (2 * GUARD_BITS));
                wzs = longint'(len) + zs * 256;
                wz = (wzs > 0) ? wzs : 0;
                if (wz == 0)
                begin
                    wz_zero++;
                    tx = 0;
                    ty = h / 2;
                    if (ty > h - 1)
                        ty = h - 1;
                end
                else
                begin
                    m = int_sqrt(2 * len * wz);
                    if (m == 0)
                        m = 1;
                    tx = axis_texel(xs, m, w);
                    ty = axis_texel(ys, m, h);
                end
                e.ok = 1;
                e.tx = tx[COORD_W-1:0];
                e.ty = ty[COORD_W-1:0];
                e.idx = 24'(tx + ty * w);
            end
            pending_texels.push_back(e);
        endfunction

        function void check_texel(texel_t a);
            texel_t e;
            if (pending_texels.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0d x=%0d y=%0d idx=%0d",
                         $time, a.ok, a.tx, a.ty, a.idx);
                errors++;
                return;
            end
            e = pending_texels.pop_front();
            seen++;
            if (a.ok !== e.ok)
            begin
                $display("%0t: valid_res expected %0d actual %0d", $time, e.ok, a.ok);
                errors++;
            end
            if (a.tx !== e.tx)
            begin
                $display("%0t: texel_x expected %0d actual %0d", $time, e.tx, a.tx);
                errors++;
            end
            if (a.ty !== e.ty)
            begin
                $display("%0t: texel_y expected %0d actual %0d", $time, e.ty, a.ty);
                errors++;
            end
            if (a.idx !== e.idx)
            begin
                $display("%0t: texel_index expected %0d actual %0d", $time, e.idx, a.idx);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    cfg_valid = 0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = CFG_TEX_WIDTH;
    logic [DIM_W-1:0]        cfg_data = 0;
    logic                    dir_valid = 0;
    logic                    dir_ready;
    logic signed [DIR_W-1:0] dir_x = 0;
    logic signed [DIR_W-1:0] dir_y = 0;
    logic signed [DIR_W-1:0] dir_z = 0;
    logic                    res_valid;
    logic                    res_ready = 0;
    logic                    valid_res;
    logic [COORD_W-1:0]      texel_x;
    logic [COORD_W-1:0]      texel_y;
    logic [INDEX_W-1:0]      texel_index;

    texel_scoreboard sb = new();
    int  send_idle_pct = 18;
    int  recv_idle_pct = 47;
    int  hold_left = 0;
    int  cycles = 0;
    int  sent = 0;

    sphere_map_texel_address uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("sphere_map_texel_address regression: fail");
            $finish;
        end
    end

    // receiver: long hold-off counted here, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 0;
        end
        else
            res_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // sample mid-cycle, the transfer happens at the next rising edge
    always @(negedge clk)
        if (rst_n && res_valid && res_ready)
            sb.check_texel('{valid_res, texel_x, texel_y, texel_index});

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(cfg_idx_t idx, bit [DIM_W-1:0] data);
        bit done;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
            done = cfg_ready;
            @(posedge clk);
        end
        while (!done);
        case (idx)
            CFG_TEX_WIDTH:   sb.width_reg = data;
            CFG_TEX_HEIGHT:  sb.height_reg = data;
            CFG_TEX_PRESENT: sb.present_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_image(bit [DIM_W-1:0] w, bit [DIM_W-1:0] h, bit present);
        write_reg(CFG_TEX_WIDTH, w);
        write_reg(CFG_TEX_HEIGHT, h);
        write_reg(CFG_TEX_PRESENT, {12'd0, present});
        cfg_valid <= 0;
    endtask

    task automatic send_dir(bit [DIR_W-1:0] x, bit [DIR_W-1:0] y, bit [DIR_W-1:0] z);
        bit done;
        if ($urandom_range(99) < send_idle_pct)
        begin
            dir_valid <= 0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        dir_valid <= 1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        do
        begin
            @(negedge clk);
            done = dir_ready;
            @(posedge clk);
        end
        while (!done);
        sb.note_dir(x, y, z);
        sent++;
    endtask

    task automatic drain();
        dir_valid <= 0;
        while (sb.pending_texels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_dirs(int n);
        bit [DIR_W-1:0] x, y, z;
        repeat (n)
        begin
            x = DIR_W'($urandom);
            y = DIR_W'($urandom);
            z = DIR_W'($urandom);
            case ($urandom_range(5))
                0:
                begin
                    // close to the minus-z pole, edge of the map
                    x = DIR_W'($urandom_range(64) - 32);
                    y = DIR_W'($urandom_range(64) - 32);
                    z = DIR_W'(32'h8000 + $urandom_range(255));
                end
                1:
                begin
                    // small magnitudes stress the rounding
                    x = DIR_W'($urandom_range(8) - 4);
                    y = DIR_W'($urandom_range(8) - 4);
                    z = DIR_W'($urandom_range(8) - 4);
                end
                default: ;
            endcase
            send_dir(x, y, z);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset state: no texture, every field zero
        send_dir(16'h7fff, 16'h8000, 16'h0001);
        random_dirs(10);
        drain();

        set_image(4096, 4096, 1);
        send_dir(0, 0, 0);
        send_dir(0, 0, 16'h8000);
        send_dir(0, 0, 16'hc000);
        send_dir(0, 0, 16'h7fff);
        send_dir(16'h7fff, 0, 0);
        send_dir(16'h8000, 0, 0);
        send_dir(0, 16'h7fff, 0);
        send_dir(0, 16'h8000, 0);
        send_dir(16'h8000, 16'h8000, 16'h8000);
        send_dir(16'h7fff, 16'h7fff, 16'h7fff);
        send_dir(16'h5555, 16'haaaa, 16'h5555);
        send_dir(16'haaaa, 16'h5555, 16'haaaa);
        send_dir(1, 0, 16'hc000);
        send_dir(16'hffff, 16'hffff, 16'h8001);
        send_dir(1, 1, 1);
        send_dir(16'hffff, 16'hffff, 16'hffff);
        send_dir(16'h4000, 16'hc000, 0);
        random_dirs(230);
        drain();

        // register zero is used as one
        set_image(0, 0, 1);
        random_dirs(200);
        drain();

        // out of range registers clamp to the largest image
        set_image(8191, 8191, 1);
        send_dir(0, 0, 16'h8000);
        hold_left = 400;
        random_dirs(250);
        drain();

        send_idle_pct = 47;
        recv_idle_pct = 18;
        set_image(640, 480, 1);
        random_dirs(250);
        drain();

        set_image(2, 3, 1);
        random_dirs(200);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_image(1, 4096, 1);
        random_dirs(200);
        drain();

        set_image(4095, 17, 0);
        random_dirs(190);
        drain();

        repeat (80) @(posedge clk);
        $display("%0d directions sent, %0d texels checked, %0d on the pole",
                 sent, sb.seen, sb.wz_zero);
        $display("image sizes from 0 to 8191 registers, texture on and off");
        if (sb.errors == 0 && sb.pending_texels.size() == 0)
            $display("sphere_map_texel_address regression: pass");
        else
            $display("sphere_map_texel_address regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
design/smap_pkg.sv
design/smap_sqrt_cell.sv
design/smap_div_cell.sv
design/sphere_map_texel_address.sv
tb/sv/sphere_map_texel_address_test.sv
